// File: design/apmc_pkg.sv
// ----------------------------------------------------------------------------
// apmc_pkg
// Shared types and constants of the pattern match counter: payload structs,
// register map and default sizes.
// ----------------------------------------------------------------------------
package apmc_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // register file geometry
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int PAT_REG_W  = 64;
  localparam int PAT_BYTES  = 16;   // bytes held by the two pattern registers
  localparam int LEN_W      = 5;
  localparam int TOTAL_W    = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  // register indexes (byte address = 8 * index)
  localparam logic [1:0] REG_PAT_LO = 2'd0;
  localparam logic [1:0] REG_PAT_HI = 2'd1;
  localparam logic [1:0] REG_PAT_LEN = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic               match_here;
    logic [TOTAL_W-1:0] match_total;
    logic               text_done;
  } out_item_t;

endpackage

// File: design/automaton_pattern_match_counter.sv
// ----------------------------------------------------------------------------
// automaton_pattern_match_counter
// Streaming matcher counting overlapping occurrences of a configured pattern.
// ----------------------------------------------------------------------------
// Path: the input transaction loads the input register, then one automaton
//   step writes the result register.
// Throughput: one byte per cycle while results are taken; the step reads a registered border table.
// Reset: synchronous, clears state, count and the valid flags of both pipeline
//   registers; pattern bytes reset to zero and pattern length to one.
module automaton_pattern_match_counter
  import apmc_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int QW = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX-1:0][7:0]           pat_bytes;
  logic [QW-1:0]                         eff_len;
  logic [PATTERN_MAX:0][PATTERN_MAX-1:0] border;

  apmc_regs #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .pat_bytes  (pat_bytes),
    .eff_len    (eff_len),
    .border     (border)
  );

  apmc_step #(
    .PATTERN_MAX(PATTERN_MAX),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .pat_bytes(pat_bytes),
    .eff_len  (eff_len),
    .border   (border)
  );

endmodule

// File: design/apmc_table.sv
// ----------------------------------------------------------------------------
// apmc_table
// Border table of the pattern: entry [q][j] is set when the pattern prefix
// of length j is a suffix of the pattern prefix of length q.
// ----------------------------------------------------------------------------
module apmc_table
  import apmc_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic [PAT_REG_W-1:0]                 pat_lo,
  input  logic [PAT_REG_W-1:0]                 pat_hi,
  output logic [PATTERN_MAX:0][PATTERN_MAX-1:0] border
);

  localparam int PadBytes = (PATTERN_MAX > PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int PadW     = 8 * PadBytes;

  logic [PadW-1:0]                 padded;
  logic [PATTERN_MAX-1:0][7:0]     pb;

  // positions past the two registers read as zero
  assign padded = PadW'({pat_hi, pat_lo});

  always_comb begin
    logic ok;
    ok = 1'b0;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      pb[p] = padded[8*p +: 8];
    end
    for (int q = 0; q <= PATTERN_MAX; q++) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        ok = (j <= q);
        for (int i = 0; i < PATTERN_MAX; i++) begin
          if (i < j && j <= q) begin
            if (pb[i] != pb[q-j+i]) begin
              ok = 1'b0;
            end
          end
        end
        border[q][j] = ok;
      end
    end
  end

endmodule

// File: design/apmc_regs.sv
// ----------------------------------------------------------------------------
// apmc_regs
// APB register file: pattern bytes and length, plus the registered border
// table rebuilt from the values being written.
// ----------------------------------------------------------------------------
module apmc_regs
  import apmc_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  localparam int QW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]                 cfg_paddr,
  input  logic [CFG_DATA_W-1:0]                 cfg_pwdata,
  output logic [CFG_DATA_W-1:0]                 cfg_prdata,
  output logic                                  cfg_pready,
  output logic [PATTERN_MAX-1:0][7:0]           pat_bytes,
  output logic [QW-1:0]                         eff_len,
  output logic [PATTERN_MAX:0][PATTERN_MAX-1:0] border
);

  localparam int PadBytes = (PATTERN_MAX > PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int PadW     = 8 * PadBytes;

  logic [PAT_REG_W-1:0] pat_lo_r, pat_lo_nxt;
  logic [PAT_REG_W-1:0] pat_hi_r, pat_hi_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [PATTERN_MAX:0][PATTERN_MAX-1:0] border_r, border_nxt;

  logic       wr;
  logic [1:0] idx;
  logic [PadW-1:0] padded;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx = cfg_paddr[CFG_ADDR_W-1:3];

  always_comb begin
    pat_lo_nxt = pat_lo_r;
    pat_hi_nxt = pat_hi_r;
    len_nxt    = len_r;
    if (!rst_n) begin
      pat_lo_nxt = '0;
      pat_hi_nxt = '0;
      len_nxt    = LEN_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_PAT_LO:  pat_lo_nxt = cfg_pwdata[PAT_REG_W-1:0];
        REG_PAT_HI:  pat_hi_nxt = cfg_pwdata[PAT_REG_W-1:0];
        REG_PAT_LEN: len_nxt    = cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // table follows the values about to be stored, so it is ready with them
  apmc_table #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_table (
    .pat_lo(pat_lo_nxt),
    .pat_hi(pat_hi_nxt),
    .border(border_nxt)
  );

  always_ff @(posedge clk) begin
    pat_lo_r <= pat_lo_nxt;
    pat_hi_r <= pat_hi_nxt;
    len_r    <= len_nxt;
    border_r <= border_nxt;
  end

  always_comb begin
    unique case (idx)
      REG_PAT_LO:  cfg_prdata = CFG_DATA_W'(pat_lo_r);
      REG_PAT_HI:  cfg_prdata = CFG_DATA_W'(pat_hi_r);
      REG_PAT_LEN: cfg_prdata = CFG_DATA_W'(len_r);
      default:     cfg_prdata = '0;
    endcase
  end

  assign padded = PadW'({pat_hi_r, pat_lo_r});

  always_comb begin
    for (int p = 0; p < PATTERN_MAX; p++) begin
      pat_bytes[p] = padded[8*p +: 8];
    end
  end

  // length zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (len_r == '0) begin
      eff_len = QW'(1);
    end else if (int'(len_r) > PATTERN_MAX) begin
      eff_len = QW'(PATTERN_MAX);
    end else begin
      eff_len = QW'(len_r);
    end
  end

  assign border = border_r;

endmodule

// File: design/apmc_step.sv
// ----------------------------------------------------------------------------
// apmc_step
// Input register, one automaton step with match counting, and the result
// register.
// ----------------------------------------------------------------------------
module apmc_step
  import apmc_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int QW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  in_item_t                              in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output out_item_t                             out_item,
  input  logic [PATTERN_MAX-1:0][7:0]           pat_bytes,
  input  logic [QW-1:0]                         eff_len,
  input  logic [PATTERN_MAX:0][PATTERN_MAX-1:0] border
);

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r, in_item_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic [QW-1:0]          state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  logic                   advance;
  logic [QW-1:0]          q;
  logic [QW-1:0]          kmax;
  logic [QW-1:0]          k_sel;
  logic [PATTERN_MAX-1:0] row;
  logic                   hit;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [63:0]            count_ext;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // automaton step
  always_comb begin
    q = (state_r > eff_len) ? '0 : state_r;
    kmax = (int'(q) + 1 < int'(eff_len)) ? q + QW'(1) : eff_len;
    row = border[q];
    k_sel = '0;
    for (int k = 1; k <= PATTERN_MAX; k++) begin
      if (k <= int'(kmax) && row[k-1] && pat_bytes[k-1] == in_item_r.text_byte) begin
        k_sel = QW'(k);
      end
    end
    hit = (k_sel == eff_len);
    count_inc = (hit && count_r != '1) ? count_r + COUNT_WIDTH'(1) : count_r;
    count_ext = 64'(count_inc);
  end

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_item_nxt   = in_item_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    state_nxt     = state_r;
    count_nxt     = count_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
      in_item_nxt  = in_item;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.match_here  = hit;
      out_item_nxt.match_total = count_ext[TOTAL_W-1:0];
      out_item_nxt.text_done   = in_item_r.text_end;
      // end of text: result carries the count, then everything restarts
      state_nxt = in_item_r.text_end ? '0 : k_sel;
      count_nxt = in_item_r.text_end ? '0 : count_inc;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      count_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
      count_r     <= count_nxt;
    end
    in_item_r  <= in_item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pattern match counter. A directed table covers
// reset defaults, length clamping, state carried across pattern changes and
// end-of-text clearing. Random phases with small-alphabet patterns and text
// built from pattern copies follow. Each result is checked against an
// in-bench automaton model or a directed row's expected result.
// ----------------------------------------------------------------------------
module tb_top;
  import apmc_pkg::*;

  localparam int HOLD_OFF_CYCLES = 150;
  localparam int RANDOM_BYTES    = 1450;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;

  typedef enum logic [1:0] {ROW_WRITE, ROW_BYTE, ROW_BYTE_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] reg_idx;
    logic [63:0] value;
    in_item_t   item;
    out_item_t  want;
  } stim_row_t;

  localparam in_item_t  NO_BYTE   = '0;
  localparam out_item_t NO_RESULT = '0;

  localparam int DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset pattern is one zero byte
    '{ROW_BYTE_KNOWN, REG_PAT_LO, 64'h0, '{8'h00, 1'b0}, '{1'b1, 32'd1, 1'b0}},
    '{ROW_BYTE_KNOWN, REG_PAT_LO, 64'h0, '{8'hFF, 1'b1}, '{1'b0, 32'd1, 1'b1}},
    // zero length acts as one
    '{ROW_WRITE, REG_PAT_LEN, 64'd0, NO_BYTE, NO_RESULT},
    '{ROW_BYTE_KNOWN, REG_PAT_LO, 64'h0, '{8'h00, 1'b1}, '{1'b1, 32'd1, 1'b1}},
    // "aba": overlapping hits, a foreign byte drops the state
    '{ROW_WRITE, REG_PAT_LO, 64'h6261_6261_6261_6261, NO_BYTE, NO_RESULT},
    '{ROW_WRITE, REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF, NO_BYTE, NO_RESULT},
    '{ROW_WRITE, REG_PAT_LEN, 64'd3, NO_BYTE, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_A, 1'b0}, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_B, 1'b0}, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_A, 1'b0}, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_B, 1'b0}, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_A, 1'b0}, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{8'h00, 1'b0}, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_A, 1'b0}, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_B, 1'b0}, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_A, 1'b1}, NO_RESULT},
    // leave state at 2, then shrink the length under it
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_A, 1'b0}, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_B, 1'b0}, NO_RESULT},
    '{ROW_WRITE, REG_PAT_LEN, 64'd1, NO_BYTE, NO_RESULT},
    '{ROW_BYTE_KNOWN, REG_PAT_LO, 64'h0, '{CH_A, 1'b0}, '{1'b1, 32'd1, 1'b0}},
    // pattern byte swapped while state is 1
    '{ROW_WRITE, REG_PAT_LO, 64'h62, NO_BYTE, NO_RESULT},
    '{ROW_BYTE, REG_PAT_LO, 64'h0, '{CH_B, 1'b1}, NO_RESULT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // model copy of registers and automaton state
  logic [63:0]      pat_lo_r = '0;
  logic [63:0]      pat_hi_r = '0;
  logic [LEN_W-1:0] pat_len_r = LEN_RESET;
  logic [4:0]       automaton_state = '0;
  logic [31:0]      match_count = '0;

  out_item_t match_reports_q [$];
  out_item_t report_want;
  int        fail_count = 0;
  bit        sender_idles = 1'b1;
  bit        receiver_idles = 1'b1;
  bit        hold_off_req = 1'b0;

  automaton_pattern_match_counter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] pattern_at(int pos);
    if (pos < 8) return pat_lo_r[8*pos +: 8];
    if (pos < 16) return pat_hi_r[8*(pos-8) +: 8];
    return 8'h00;
  endfunction

  function automatic int active_length();
    int m;
    m = pat_len_r;
    if (m < 1) m = 1;
    if (m > PATTERN_MAX_DEF) m = PATTERN_MAX_DEF;
    return m;
  endfunction

  // One automaton step: longest pattern prefix ending (prefix of q) + byte.
  function automatic out_item_t automaton_advance(in_item_t item);
    int m, q, k, i, start;
    bit fits, found;
    out_item_t res;
    m = active_length();
    q = automaton_state;
    if (q > m) q = 0;
    k = (q + 1 < m) ? q + 1 : m;
    found = 1'b0;
    while (!found && k > 0) begin
      fits = (pattern_at(k - 1) == item.text_byte);
      start = q + 1 - k;
      for (i = 0; i + 1 < k && fits; i++) begin
        if (pattern_at(i) != pattern_at(start + i)) fits = 1'b0;
      end
      if (fits) found = 1'b1;
      else k--;
    end
    res.match_here = (k == m);
    if (res.match_here && match_count != '1) match_count = match_count + 32'd1;
    automaton_state = 5'(k);
    res.match_total = match_count;
    res.text_done   = item.text_end;
    if (item.text_end) begin
      automaton_state = '0;
      match_count     = '0;
    end
    return res;
  endfunction

  function automatic bit count_failure();
    fail_count++;
    return fail_count <= 10;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 3'b000});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_PAT_LO:  pat_lo_r = value;
      REG_PAT_HI:  pat_hi_r = value;
      REG_PAT_LEN: pat_len_r = value[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // sender stops, every result drains, then pipeline latency passes
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (match_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_text_byte(input in_item_t item, input bit known,
                                input out_item_t known_res);
    int gap;
    out_item_t predicted;
    gap = sender_idles ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = automaton_advance(item);
    match_reports_q.push_back(known ? known_res : predicted);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (match_reports_q.size() == 0) begin
        if (count_failure())
          $display("%0t: unexpected result hit=%0d total=%0d done=%0d", $time,
                   out_item.match_here, out_item.match_total, out_item.text_done);
      end else begin
        report_want = match_reports_q.pop_front();
        if (out_item.match_here !== report_want.match_here ||
            out_item.match_total !== report_want.match_total ||
            out_item.text_done !== report_want.text_done) begin
          if (count_failure())
            $display("%0t: mismatch exp hit=%0d total=%0d done=%0d, got hit=%0d total=%0d done=%0d",
                     $time, report_want.match_here, report_want.match_total,
                     report_want.text_done, out_item.match_here,
                     out_item.match_total, out_item.text_done);
        end
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = receiver_idles ? $urandom_range(0, 7) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    in_item_t    item;
    logic [7:0]  alpha [3];
    logic [63:0] lo_val, hi_val;
    int alpha_n, len_val, pick, span, n, i, phase, random_sent;
    bit write_lo, write_hi, write_len;
    logic [7:0] text_pending [$];

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      case (DIRECTED[r].kind)
        ROW_WRITE: begin
          settle_idle();
          apb_write(DIRECTED[r].reg_idx, DIRECTED[r].value);
        end
        ROW_BYTE:  send_text_byte(DIRECTED[r].item, 1'b0, NO_RESULT);
        default:   send_text_byte(DIRECTED[r].item, 1'b1, DIRECTED[r].want);
      endcase
    end

    alpha_n = 1;
    alpha[0] = 8'h00;
    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      settle_idle();
      // first phases pin the extremes: all-zero and all-ones patterns
      write_lo  = (phase < 3) || ($urandom_range(0, 3) != 0);
      write_hi  = (phase < 3) || ($urandom_range(0, 3) != 0);
      write_len = (phase < 3) || ($urandom_range(0, 3) != 0);
      if (write_lo && write_hi) begin
        alpha_n = $urandom_range(1, 3);
        for (i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(0, 255));
        if (phase == 0) begin
          alpha_n = 1;
          alpha[0] = 8'h00;
        end else if (phase == 1) begin
          alpha_n = 1;
          alpha[0] = 8'hFF;
        end
      end
      for (i = 0; i < 8; i++) begin
        lo_val[8*i +: 8] = alpha[$urandom_range(0, alpha_n - 1)];
        hi_val[8*i +: 8] = alpha[$urandom_range(0, alpha_n - 1)];
      end
      case (phase)
        0: len_val = 31;
        1: len_val = 16;
        2: len_val = 0;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) len_val = 0;
          else if (pick == 1) len_val = 16;
          else if (pick == 2) len_val = $urandom_range(17, 31);
          else if (pick == 3) len_val = $urandom_range(7, 15);
          else len_val = $urandom_range(1, 6);
        end
      endcase
      if (write_lo) apb_write(REG_PAT_LO, lo_val);
      if (write_hi) apb_write(REG_PAT_HI, hi_val);
      if (write_len) apb_write(REG_PAT_LEN, 64'(len_val));

      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      if (phase == 4 || phase == 19) hold_off_req = 1'b1;

      // text is mostly pattern copies and prefixes, with some foreign bytes
      text_pending.delete();
      n = $urandom_range(25, 60);
      repeat (n) begin
        if (text_pending.size() == 0) begin
          span = active_length();
          pick = $urandom_range(0, 19);
          if (pick < 14) begin
            if (pick >= 9) span = $urandom_range(1, span);
            for (i = 0; i < span; i++) text_pending.push_back(pattern_at(i));
          end else if (pick < 18) begin
            text_pending.push_back(alpha[$urandom_range(0, alpha_n - 1)]);
          end else begin
            text_pending.push_back(8'($urandom_range(0, 255)));
          end
        end
        item.text_byte = text_pending.pop_front();
        item.text_end  = ($urandom_range(0, 29) == 0);
        send_text_byte(item, 1'b0, NO_RESULT);
        random_sent++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (match_reports_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (match_reports_q.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", match_reports_q.size());
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
